>>> rtl/vtk_pkg.sv
`timescale 1ns / 1ps

package vtk_pkg;

    // field widths of the block's ports
    localparam int REQ_W     = 2;
    localparam int COMP_W    = 16;
    localparam int BOOK_W    = 10;
    localparam int META_W    = 16;
    localparam int STATUS_W  = 3;
    localparam int SCORE_W   = 58;
    localparam int DIMS_W    = 11;
    localparam int HITS_W    = 3;
    localparam int CFG_IDX_W = 2;
    localparam int PEAK_W    = 16;
    // vector length carried with a job, wide enough for the largest buffer plus one
    localparam int JOB_N_W   = 13;
    // numerator of the rounding divide: 2*mag*127 + peak
    localparam int QNUM_W    = 23;
    localparam int QUO_W     = 7;

    // request codes
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ROW   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_STORED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HITS = 2'd1;

    localparam logic [DIMS_W-1:0] DIMS_RESET = 11'd384;
    localparam logic [HITS_W-1:0] HITS_RESET = 3'd3;

    localparam int QUANT_MAX2 = 254;

    // one finished vector or clear request handed from front to back
    typedef struct packed {
        logic [REQ_W-1:0]   kind;
        logic               ok_len;
        logic [JOB_N_W-1:0] n;
        logic [PEAK_W-1:0]  peak;
        logic [BOOK_W-1:0]  book;
        logic [META_W-1:0]  chapter;
        logic [META_W-1:0]  verse;
    } job_t;

endpackage

>>> rtl/vtk_front.sv
`timescale 1ns / 1ps

module vtk_front #(
    parameter int MAX_DIMS = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [vtk_pkg::REQ_W-1:0]    req_type,
    input  logic signed [vtk_pkg::COMP_W-1:0] component,
    input  logic                         last_component,
    input  logic [vtk_pkg::BOOK_W-1:0]   book_id,
    input  logic [vtk_pkg::META_W-1:0]   chapter_num,
    input  logic [vtk_pkg::META_W-1:0]   verse_num,
    input  logic [vtk_pkg::DIMS_W-1:0]   dims_in_use,
    input  logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] rd_addr,
    output logic signed [vtk_pkg::COMP_W-1:0] rd_data,
    output logic                         push,
    output vtk_pkg::job_t                push_job
);
    import vtk_pkg::*;

    localparam int DIX_W = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int FC_W  = $clog2(MAX_DIMS + 2);

    logic signed [COMP_W-1:0] vec_mem [0:MAX_DIMS-1];
    logic signed [COMP_W-1:0] rd_data_reg;

    logic [FC_W-1:0]   count_reg, count_next, count_inc;
    logic [PEAK_W-1:0] peak_reg, peak_next, peak_upd;
    logic [PEAK_W-1:0] mag;
    logic              is_vec;
    logic              buf_we;
    logic              ok_len;

    // magnitude and running peak of this beat
    assign mag      = component[COMP_W-1] ? PEAK_W'(-component) : PEAK_W'(component);
    assign peak_upd = (mag > peak_reg) ? mag : peak_reg;
    assign is_vec   = (req_type == REQ_ROW) || (req_type == REQ_QUERY);
    assign count_inc = (32'(count_reg) <= MAX_DIMS) ? count_reg + FC_W'(1) : count_reg;
    assign ok_len   = (32'(count_inc) == 32'(dims_in_use)) && (32'(count_inc) <= MAX_DIMS);
    assign buf_we   = accept && is_vec && (32'(count_reg) < MAX_DIMS);

    // collect state and job hand-off
    always_comb
    begin
        count_next       = count_reg;
        peak_next        = peak_reg;
        push             = 1'b0;
        push_job.kind    = req_type;
        push_job.ok_len  = ok_len;
        push_job.n       = JOB_N_W'(count_inc);
        push_job.peak    = peak_upd;
        push_job.book    = book_id;
        push_job.chapter = chapter_num;
        push_job.verse   = verse_num;
        if (accept)
        begin
            if (req_type == REQ_CLEAR)
            begin
                count_next = '0;
                peak_next  = '0;
                push       = 1'b1;
            end
            else if (is_vec)
            begin
                if (last_component)
                begin
                    count_next = '0;
                    peak_next  = '0;
                    push       = 1'b1;
                end
                else
                begin
                    count_next = count_inc;
                    peak_next  = peak_upd;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            peak_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            peak_reg  <= peak_next;
        end
    end

    // vector buffer, read by the back end
    always_ff @(posedge clk)
    begin
        if (buf_we)
            vec_mem[count_reg[DIX_W-1:0]] <= component;
        rd_data_reg <= vec_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/vtk_job_fifo.sv
`timescale 1ns / 1ps

module vtk_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  vtk_pkg::job_t push_job,
    input  logic          pop,
    output logic          empty,
    output vtk_pkg::job_t head
);
    import vtk_pkg::*;

    job_t       slot_mem [0:1];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign empty = (fill_reg == 2'd0);
    assign head  = slot_mem[rd_ptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    // job slots
    always_ff @(posedge clk)
    begin
        if (push)
            slot_mem[wr_ptr_reg] <= push_job;
    end

endmodule

>>> rtl/vtk_back.sv
`timescale 1ns / 1ps

module vtk_back #(
    parameter int MAX_DIMS = 1024,
    parameter int MAX_ROWS = 4096,
    parameter int MAX_HITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               job_avail,
    input  vtk_pkg::job_t                      job,
    output logic                               pop,
    output logic                               idle,
    input  logic [vtk_pkg::HITS_W-1:0]         hits_wanted,
    output logic [(MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1)-1:0] vb_addr,
    input  logic signed [vtk_pkg::COMP_W-1:0]  vb_data,
    output logic                               result_valid,
    output logic [vtk_pkg::STATUS_W-1:0]       status,
    output logic [vtk_pkg::BOOK_W-1:0]         hit_book,
    output logic [vtk_pkg::META_W-1:0]         hit_chapter,
    output logic [vtk_pkg::META_W-1:0]         hit_verse,
    output logic signed [vtk_pkg::SCORE_W-1:0] hit_score,
    output logic                               last_result
);
    import vtk_pkg::*;

    localparam int DIX_W  = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;
    localparam int DC_W   = $clog2(MAX_DIMS + 1);
    localparam int RIX_W  = MAX_ROWS > 1 ? $clog2(MAX_ROWS) : 1;
    localparam int RS_W   = $clog2(MAX_ROWS + 1);
    localparam int RA_W   = (MAX_ROWS * MAX_DIMS) > 1 ? $clog2(MAX_ROWS * MAX_DIMS) : 1;
    localparam int HC_W   = $clog2(MAX_HITS + 1);
    localparam int HIX_W  = MAX_HITS > 1 ? $clog2(MAX_HITS) : 1;
    localparam int ACC_W  = 16 + $clog2(MAX_DIMS + 1);
    localparam int PP_W   = 2 * PEAK_W;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_QRD   = 14'b00000000000010,
        S_QLD   = 14'b00000000000100,
        S_QDIV  = 14'b00000000001000,
        S_RFIN  = 14'b00000000010000,
        S_MRD   = 14'b00000000100000,
        S_MCHK  = 14'b00000001000000,
        S_DOT   = 14'b00000010000000,
        S_DRAIN = 14'b00000100000000,
        S_SC1   = 14'b00001000000000,
        S_SC2   = 14'b00010000000000,
        S_INS   = 14'b00100000000000,
        S_EST   = 14'b01000000000000,
        S_EOUT  = 14'b10000000000000
    } state_t;

    // row storage and per-row metadata
    logic signed [7:0]  row_mem   [0:MAX_ROWS*MAX_DIMS-1];
    logic signed [7:0]  qq_mem    [0:MAX_DIMS-1];
    logic [PEAK_W-1:0]  peak_mem  [0:MAX_ROWS-1];
    logic [DC_W-1:0]    len_mem   [0:MAX_ROWS-1];
    logic [BOOK_W-1:0]  book_mem  [0:MAX_ROWS-1];
    logic [META_W-1:0]  chap_mem  [0:MAX_ROWS-1];
    logic [META_W-1:0]  verse_mem [0:MAX_ROWS-1];

    state_t state_reg, state_next;
    job_t   job_reg, job_next;

    logic [DC_W-1:0]   d_reg, d_next, n_reg, n_next;
    logic [QNUM_W-1:0] rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              neg_reg, neg_next;
    logic [2:0]        step_reg, step_next;
    logic [RS_W-1:0]   rows_reg, rows_next, r_reg, r_next;
    logic [RA_W-1:0]   wbase_reg, wbase_next, rbase_reg, rbase_next;
    logic [HC_W-1:0]   k_reg, k_next, bcnt_reg, bcnt_next, e_reg, e_next;
    logic [PEAK_W-1:0] rpeak_reg, rpeak_next;
    logic [DC_W-1:0]   rlen_reg, rlen_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [PP_W-1:0]           pp_reg, pp_next;
    logic signed [SCORE_W-1:0] score_reg, score_next;
    logic signed [SCORE_W-1:0] best_score_reg [0:MAX_HITS-1];
    logic signed [SCORE_W-1:0] best_score_next [0:MAX_HITS-1];
    logic [RIX_W-1:0]          best_row_reg [0:MAX_HITS-1];
    logic [RIX_W-1:0]          best_row_next [0:MAX_HITS-1];

    // dot product pipeline
    logic              v1_reg, v2_reg, rin1_reg;
    logic signed [7:0] row_rd_reg, qq_rd_reg;
    logic signed [15:0] prod_reg;

    // metadata read port
    logic [PEAK_W-1:0] peak_rd_reg;
    logic [DC_W-1:0]   len_rd_reg;
    logic [BOOK_W-1:0] book_rd_reg;
    logic [META_W-1:0] chap_rd_reg, verse_rd_reg;
    logic [RIX_W-1:0]  meta_raddr;

    // result registers
    logic                valid_reg, valid_next, last_reg, last_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BOOK_W-1:0]   book_reg, book_next;
    logic [META_W-1:0]   chap_reg, chap_next, verse_reg, verse_next;
    logic signed [SCORE_W-1:0] oscore_reg, oscore_next;

    // divider step
    logic              div_ge;
    logic [QUO_W-1:0]  quo_step;
    logic [7:0]        qmag, qval;
    logic              row_we, qq_we, meta_we;
    logic [RA_W-1:0]   row_waddr, row_raddr;
    logic [HC_W-1:0]   hits_sat;
    logic [15:0]       mag_in;
    logic signed [ACC_W+PP_W:0] score_full;

    // insertion into the best list
    logic [HC_W-1:0]   ins_pos;
    logic              ins_take;
    logic [HIX_W-1:0]  e_ix;

    assign div_ge   = rem_reg >= dsh_reg;
    assign quo_step = {quo_reg[QUO_W-2:0], div_ge};
    assign qmag     = {1'b0, quo_step};
    assign qval     = neg_reg ? (8'd0 - qmag) : qmag;
    assign row_waddr = wbase_reg + RA_W'(d_reg);
    assign row_raddr = rbase_reg + RA_W'(d_reg);
    assign vb_addr  = d_reg[DIX_W-1:0];
    assign hits_sat = (32'(hits_wanted) > MAX_HITS) ? HC_W'(MAX_HITS) : HC_W'(hits_wanted);
    assign mag_in   = vb_data[COMP_W-1] ? 16'(-vb_data) : 16'(vb_data);
    assign score_full = (ACC_W+PP_W+1)'(acc_reg) * $signed({1'b0, pp_reg});
    assign e_ix     = e_reg[HIX_W-1:0];
    assign meta_raddr = (state_reg == S_EST || state_reg == S_EOUT) ? best_row_reg[e_ix]
                                                                    : r_reg[RIX_W-1:0];
    assign row_we   = (state_reg == S_QDIV) && (step_reg == 3'd0) && (job_reg.kind == REQ_ROW);
    assign qq_we    = (state_reg == S_QDIV) && (step_reg == 3'd0) && (job_reg.kind != REQ_ROW);
    assign meta_we  = (state_reg == S_RFIN);

    // place of a new score: behind every kept entry that is at least as good
    always_comb
    begin
        ins_pos = '0;
        for (int j = 0; j < MAX_HITS; j++)
        begin
            if ((HC_W'(j) < bcnt_reg) && (best_score_reg[j] >= score_reg))
                ins_pos = ins_pos + HC_W'(1);
        end
        ins_take = ins_pos < k_reg;
    end

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        job_next    = job_reg;
        d_next      = d_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        dsh_next    = dsh_reg;
        quo_next    = quo_reg;
        neg_next    = neg_reg;
        step_next   = step_reg;
        rows_next   = rows_reg;
        r_next      = r_reg;
        wbase_next  = wbase_reg;
        rbase_next  = rbase_reg;
        k_next      = k_reg;
        bcnt_next   = bcnt_reg;
        e_next      = e_reg;
        rpeak_next  = rpeak_reg;
        rlen_next   = rlen_reg;
        acc_next    = acc_reg;
        pp_next     = pp_reg;
        score_next  = score_reg;
        for (int j = 0; j < MAX_HITS; j++)
        begin
            best_score_next[j] = best_score_reg[j];
            best_row_next[j]   = best_row_reg[j];
        end
        valid_next  = 1'b0;
        last_next   = 1'b1;
        status_next = status_reg;
        book_next   = '0;
        chap_next   = '0;
        verse_next  = '0;
        oscore_next = '0;
        pop         = 1'b0;

        // accumulate the dot product pipeline tail
        if (v2_reg)
            acc_next = acc_reg + ACC_W'(prod_reg);

        case (state_reg)
            S_IDLE:
            begin
                if (job_avail)
                begin
                    pop      = 1'b1;
                    job_next = job;
                    n_next   = DC_W'(job.n);
                    d_next   = '0;
                    k_next   = hits_sat;
                    case (job.kind)
                        REQ_CLEAR:
                        begin
                            rows_next   = '0;
                            wbase_next  = '0;
                            bcnt_next   = '0;
                            valid_next  = 1'b1;
                            status_next = ST_CLEARED;
                        end
                        REQ_ROW:
                        begin
                            if (!job.ok_len)
                            begin
                                rows_next   = '0;
                                wbase_next  = '0;
                                valid_next  = 1'b1;
                                status_next = ST_MISMATCH;
                            end
                            else if (32'(rows_reg) >= MAX_ROWS)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_FULL;
                            end
                            else if (job.peak == '0)
                                state_next = S_RFIN;
                            else
                                state_next = S_QRD;
                        end
                        REQ_QUERY:
                        begin
                            bcnt_next = '0;
                            if (rows_reg == '0 || hits_sat == '0 || !job.ok_len
                                || job.peak == '0)
                            begin
                                valid_next  = 1'b1;
                                status_next = ST_NONE;
                            end
                            else
                                state_next = S_QRD;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_QRD:
            begin
                state_next = S_QLD;
            end
            S_QLD:
            begin
                neg_next   = vb_data[COMP_W-1];
                rem_next   = QNUM_W'(mag_in) * QNUM_W'(QUANT_MAX2) + QNUM_W'(job_reg.peak);
                dsh_next   = QNUM_W'({job_reg.peak, 1'b0}) << (QUO_W - 1);
                quo_next   = '0;
                step_next  = 3'(QUO_W - 1);
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                rem_next  = div_ge ? rem_reg - dsh_reg : rem_reg;
                dsh_next  = dsh_reg >> 1;
                quo_next  = quo_step;
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0)
                begin
                    d_next = d_reg + DC_W'(1);
                    if (d_reg + DC_W'(1) == n_reg)
                    begin
                        if (job_reg.kind == REQ_ROW)
                            state_next = S_RFIN;
                        else
                        begin
                            r_next     = '0;
                            rbase_next = '0;
                            state_next = S_MRD;
                        end
                    end
                    else
                        state_next = S_QRD;
                end
            end
            S_RFIN:
            begin
                rows_next   = rows_reg + RS_W'(1);
                wbase_next  = wbase_reg + RA_W'(MAX_DIMS);
                valid_next  = 1'b1;
                status_next = ST_STORED;
                state_next  = S_IDLE;
            end
            S_MRD:
            begin
                state_next = S_MCHK;
            end
            S_MCHK:
            begin
                if (peak_rd_reg == '0)
                begin
                    r_next     = r_reg + RS_W'(1);
                    rbase_next = rbase_reg + RA_W'(MAX_DIMS);
                    if (r_reg + RS_W'(1) == rows_reg)
                    begin
                        e_next     = '0;
                        state_next = S_EST;
                    end
                    else
                        state_next = S_MRD;
                end
                else
                begin
                    rpeak_next = peak_rd_reg;
                    rlen_next  = len_rd_reg;
                    d_next     = '0;
                    acc_next   = '0;
                    state_next = S_DOT;
                end
            end
            S_DOT:
            begin
                d_next = d_reg + DC_W'(1);
                if (d_reg + DC_W'(1) == n_reg)
                    state_next = S_DRAIN;
            end
            S_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                    state_next = S_SC1;
            end
            S_SC1:
            begin
                pp_next    = PP_W'(rpeak_reg) * PP_W'(job_reg.peak);
                state_next = S_SC2;
            end
            S_SC2:
            begin
                score_next = SCORE_W'(score_full);
                state_next = S_INS;
            end
            S_INS:
            begin
                if (ins_take)
                begin
                    for (int j = 0; j < MAX_HITS; j++)
                    begin
                        if (HC_W'(j) == ins_pos)
                        begin
                            best_score_next[j] = score_reg;
                            best_row_next[j]   = r_reg[RIX_W-1:0];
                        end
                        else if ((HC_W'(j) > ins_pos) && (j > 0))
                        begin
                            best_score_next[j] = best_score_reg[j-1];
                            best_row_next[j]   = best_row_reg[j-1];
                        end
                    end
                    if (bcnt_reg < k_reg)
                        bcnt_next = bcnt_reg + HC_W'(1);
                end
                r_next     = r_reg + RS_W'(1);
                rbase_next = rbase_reg + RA_W'(MAX_DIMS);
                if (r_reg + RS_W'(1) == rows_reg)
                begin
                    e_next     = '0;
                    state_next = S_EST;
                end
                else
                    state_next = S_MRD;
            end
            S_EST:
            begin
                // metadata of hit e is fetched here
                if (bcnt_reg == '0)
                begin
                    valid_next  = 1'b1;
                    status_next = ST_NONE;
                    state_next  = S_IDLE;
                end
                else
                    state_next = S_EOUT;
            end
            S_EOUT:
            begin
                valid_next  = 1'b1;
                status_next = ST_HIT;
                book_next   = book_rd_reg;
                chap_next   = chap_rd_reg;
                verse_next  = verse_rd_reg;
                oscore_next = best_score_reg[e_ix];
                last_next   = (e_reg + HC_W'(1) == bcnt_reg);
                e_next      = e_reg + HC_W'(1);
                if (e_reg + HC_W'(1) == bcnt_reg)
                    state_next = S_IDLE;
                else
                    state_next = S_EST;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rows_reg  <= '0;
            wbase_reg <= '0;
            bcnt_reg  <= '0;
            valid_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rows_reg  <= rows_next;
            wbase_reg <= wbase_next;
            bcnt_reg  <= bcnt_next;
            valid_reg <= valid_next;
            v1_reg    <= (state_reg == S_DOT);
            v2_reg    <= v1_reg;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        job_reg    <= job_next;
        d_reg      <= d_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        dsh_reg    <= dsh_next;
        quo_reg    <= quo_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        r_reg      <= r_next;
        rbase_reg  <= rbase_next;
        k_reg      <= k_next;
        e_reg      <= e_next;
        rpeak_reg  <= rpeak_next;
        rlen_reg   <= rlen_next;
        acc_reg    <= acc_next;
        pp_reg     <= pp_next;
        score_reg  <= score_next;
        for (int j = 0; j < MAX_HITS; j++)
        begin
            best_score_reg[j] <= best_score_next[j];
            best_row_reg[j]   <= best_row_next[j];
        end
        rin1_reg   <= d_reg < rlen_reg;
        prod_reg   <= (v1_reg && rin1_reg) ? 16'(row_rd_reg) * 16'(qq_rd_reg) : 16'sd0;
        last_reg   <= last_next;
        status_reg <= status_next;
        book_reg   <= book_next;
        chap_reg   <= chap_next;
        verse_reg  <= verse_next;
        oscore_reg <= oscore_next;
    end

    // quantized rows and query
    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= qval;
        if (qq_we)
            qq_mem[d_reg[DIX_W-1:0]] <= qval;
        row_rd_reg <= row_mem[row_raddr];
        qq_rd_reg  <= qq_mem[d_reg[DIX_W-1:0]];
    end

    // row metadata
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            peak_mem[rows_reg[RIX_W-1:0]]  <= job_reg.peak;
            len_mem[rows_reg[RIX_W-1:0]]   <= n_reg;
            book_mem[rows_reg[RIX_W-1:0]]  <= job_reg.book;
            chap_mem[rows_reg[RIX_W-1:0]]  <= job_reg.chapter;
            verse_mem[rows_reg[RIX_W-1:0]] <= job_reg.verse;
        end
        peak_rd_reg  <= peak_mem[meta_raddr];
        len_rd_reg   <= len_mem[meta_raddr];
        book_rd_reg  <= book_mem[meta_raddr];
        chap_rd_reg  <= chap_mem[meta_raddr];
        verse_rd_reg <= verse_mem[meta_raddr];
    end

    assign idle         = (state_reg == S_IDLE);
    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign hit_book     = book_reg;
    assign hit_chapter  = chap_reg;
    assign hit_verse    = verse_reg;
    assign hit_score    = oscore_reg;
    assign last_result  = last_reg;

endmodule

>>> rtl/int8_vector_topk_search.sv
`timescale 1ns / 1ps
// int8 vector top-k search
// Input beats arrive on start/busy: a beat is taken at a clock edge with start high
// and busy low. Each beat is one Q1.15 component of a row or query, or a clear request.
// Components are taken one per cycle while busy is low. On the last component
// of a vector the finished vector goes into a short job queue and busy stays high
// until the back end has handled it; the back end picks up a job in the cycle after
// it is queued. A row with a nonzero peak passes each component through a buffer
// read and a 7-step rounding divider and is then stored; an all-zero row skips the
// divider. A query takes the same quantize pass, then a metadata read for every
// stored row, plus a dot product and scoring for every row with a nonzero peak (one
// multiply per cycle on the row memory port), and a fetch and output per hit
// returned. Clear, mismatch, full and refused requests are answered as soon as the
// job leaves the job queue, through the result registers.
// Results appear on result_valid for exactly one cycle each; hits come best first
// and last_result marks the final one. The receiver cannot stall results.
// Reset empties the index, the best list and the partial vector, and loads
// dims_in_use = 384 and hits_wanted = 3. Row storage needs no clearing pass.
// Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
// and are to be made only while busy is low and no result is pending.

module int8_vector_topk_search #(
    parameter int MAX_DIMS = 1024,
    parameter int MAX_ROWS = 4096,
    parameter int MAX_HITS = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [vtk_pkg::REQ_W-1:0]          req_type,
    input  logic signed [vtk_pkg::COMP_W-1:0]  component,
    input  logic                               last_component,
    input  logic [vtk_pkg::BOOK_W-1:0]         book_id,
    input  logic [vtk_pkg::META_W-1:0]         chapter_num,
    input  logic [vtk_pkg::META_W-1:0]         verse_num,
    input  logic                               cfg_write,
    input  logic [vtk_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vtk_pkg::DIMS_W-1:0]         cfg_data,
    output logic                               result_valid,
    output logic [vtk_pkg::STATUS_W-1:0]       status,
    output logic [vtk_pkg::BOOK_W-1:0]         hit_book,
    output logic [vtk_pkg::META_W-1:0]         hit_chapter,
    output logic [vtk_pkg::META_W-1:0]         hit_verse,
    output logic signed [vtk_pkg::SCORE_W-1:0] hit_score,
    output logic                               last_result
);
    import vtk_pkg::*;

    localparam int DIX_W = MAX_DIMS > 1 ? $clog2(MAX_DIMS) : 1;

    logic [DIMS_W-1:0] dims_reg;
    logic [HITS_W-1:0] hits_reg;
    logic              accept;
    logic              push, pop, empty, back_idle;
    job_t              push_job, head_job;
    logic [DIX_W-1:0]  vb_addr;
    logic signed [COMP_W-1:0] vb_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dims_reg <= DIMS_RESET;
            hits_reg <= HITS_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == CFG_DIMS)
                dims_reg <= cfg_data;
            else if (cfg_index == CFG_HITS)
                hits_reg <= cfg_data[HITS_W-1:0];
        end
    end

    // beat handshake
    assign busy   = !empty || !back_idle;
    assign accept = start && !busy;

    vtk_front #(
        .MAX_DIMS (MAX_DIMS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .req_type       (req_type),
        .component      (component),
        .last_component (last_component),
        .book_id        (book_id),
        .chapter_num    (chapter_num),
        .verse_num      (verse_num),
        .dims_in_use    (dims_reg),
        .rd_addr        (vb_addr),
        .rd_data        (vb_data),
        .push           (push),
        .push_job       (push_job)
    );

    vtk_job_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .empty    (empty),
        .head     (head_job)
    );

    vtk_back #(
        .MAX_DIMS (MAX_DIMS),
        .MAX_ROWS (MAX_ROWS),
        .MAX_HITS (MAX_HITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (!empty),
        .job          (head_job),
        .pop          (pop),
        .idle         (back_idle),
        .hits_wanted  (hits_reg),
        .vb_addr      (vb_addr),
        .vb_data      (vb_data),
        .result_valid (result_valid),
        .status       (status),
        .hit_book     (hit_book),
        .hit_chapter  (hit_chapter),
        .hit_verse    (hit_verse),
        .hit_score    (hit_score),
        .last_result  (last_result)
    );

endmodule

>>> sim/int8_vector_topk_search_tb.sv
`timescale 1ns / 1ps

module int8_vector_topk_search_tb;

    import vtk_pkg::*;

    localparam int MAX_DIMS = 1024;
    localparam int MAX_ROWS = 4096;
    localparam int MAX_HITS = 4;

    typedef struct {
        logic [STATUS_W-1:0]       status;
        logic [BOOK_W-1:0]         book;
        logic [META_W-1:0]         chapter;
        logic [META_W-1:0]         verse;
        logic signed [SCORE_W-1:0] score;
        logic                      last;
    } search_result_t;

    typedef byte qvec_t[$];

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [REQ_W-1:0]           req_type = REQ_CLEAR;
    logic signed [COMP_W-1:0]   component = '0;
    logic                       last_component = 1'b0;
    logic [BOOK_W-1:0]          book_id = '0;
    logic [META_W-1:0]          chapter_num = '0;
    logic [META_W-1:0]          verse_num = '0;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = CFG_DIMS;
    logic [DIMS_W-1:0]          cfg_data = '0;
    logic                       result_valid;
    logic [STATUS_W-1:0]        status;
    logic [BOOK_W-1:0]          hit_book;
    logic [META_W-1:0]          hit_chapter;
    logic [META_W-1:0]          hit_verse;
    logic signed [SCORE_W-1:0]  hit_score;
    logic                       last_result;

    // mirror of the search state
    int unsigned    dims_cfg = DIMS_RESET;
    int unsigned    hits_cfg = HITS_RESET;
    shortint        vbuf[MAX_DIMS];
    int unsigned    elem_cnt = 0;
    int unsigned    run_peak = 0;
    int unsigned    n_rows = 0;
    qvec_t          row_q[MAX_ROWS];
    int unsigned    row_pk[MAX_ROWS];
    logic [BOOK_W-1:0] row_bk[MAX_ROWS];
    logic [META_W-1:0] row_ch[MAX_ROWS];
    logic [META_W-1:0] row_vs[MAX_ROWS];

    search_result_t due_results[$];
    int             errors = 0;
    int             burst_left = 0;
    int             rand_items = 0;

    int8_vector_topk_search dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .component     (component),
        .last_component(last_component),
        .book_id       (book_id),
        .chapter_num   (chapter_num),
        .verse_num     (verse_num),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_valid  (result_valid),
        .status        (status),
        .hit_book      (hit_book),
        .hit_chapter   (hit_chapter),
        .hit_verse     (hit_verse),
        .hit_score     (hit_score),
        .last_result   (last_result)
    );

    always #1 clk = ~clk;

    // per-vector int8 quantization, round half away from zero
    function automatic qvec_t quantize_vec(int unsigned n, int unsigned pk);
        qvec_t       q;
        int          v;
        int unsigned mag;
        int          qq;
        for (int d = 0; d < n && d < MAX_DIMS; d++)
        begin
            v = vbuf[d];
            mag = (v < 0) ? -v : v;
            qq = (pk != 0) ? int'((2 * mag * 127 + pk) / (2 * pk)) : 0;
            if (qq > 127)
                qq = 127;
            q.push_back(byte'((v < 0) ? -qq : qq));
        end
        return q;
    endfunction

    task automatic push_status(input logic [STATUS_W-1:0] st);
        search_result_t r;
        r = '{st, '0, '0, '0, '0, 1'b1};
        due_results.push_back(r);
    endtask

    // expected results of one accepted beat
    task automatic search_predict(input logic [REQ_W-1:0] t, input logic signed [COMP_W-1:0] c,
                                  input logic lc, input logic [BOOK_W-1:0] b,
                                  input logic [META_W-1:0] ch, input logic [META_W-1:0] vs);
        int             v;
        int unsigned    mag, n, pk, k, cnt, i;
        bit             ok;
        qvec_t          qq;
        longint         sc;
        longint         bsc[MAX_HITS];
        int unsigned    brw[MAX_HITS];
        int             acc;
        search_result_t r;
        if (t == 2'd3)
            return;
        if (t == REQ_CLEAR)
        begin
            n_rows = 0;
            elem_cnt = 0;
            run_peak = 0;
            push_status(ST_CLEARED);
            return;
        end
        v = c;
        if (elem_cnt < MAX_DIMS)
            vbuf[elem_cnt] = shortint'(v);
        if (elem_cnt <= MAX_DIMS)
            elem_cnt++;
        mag = (v < 0) ? -v : v;
        if (mag > run_peak)
            run_peak = mag;
        if (!lc)
            return;
        n = elem_cnt;
        pk = run_peak;
        elem_cnt = 0;
        run_peak = 0;
        ok = (n == dims_cfg) && (n <= MAX_DIMS);
        if (t == REQ_ROW)
        begin
            if (!ok)
            begin
                n_rows = 0;
                push_status(ST_MISMATCH);
            end
            else if (n_rows >= MAX_ROWS)
                push_status(ST_FULL);
            else
            begin
                row_q[n_rows] = quantize_vec(n, pk);
                row_pk[n_rows] = pk;
                row_bk[n_rows] = b;
                row_ch[n_rows] = ch;
                row_vs[n_rows] = vs;
                n_rows++;
                push_status(ST_STORED);
            end
            return;
        end
        // query: scan every ranked row
        k = (hits_cfg > MAX_HITS) ? MAX_HITS : hits_cfg;
        cnt = 0;
        if (n_rows == 0 || k == 0 || !ok || pk == 0)
        begin
            push_status(ST_NONE);
            return;
        end
        qq = quantize_vec(n, pk);
        for (int rr = 0; rr < n_rows; rr++)
        begin
            if (row_pk[rr] == 0)
                continue;
            acc = 0;
            for (int d = 0; d < n; d++)
                if (d < row_q[rr].size())
                    acc += int'(row_q[rr][d]) * int'(qq[d]);
            sc = longint'(acc) * longint'(row_pk[rr]) * longint'(pk);
            if (cnt < k)
            begin
                i = cnt;
                cnt++;
            end
            else if (sc > bsc[k-1])
                i = k - 1;
            else
                continue;
            while (i > 0 && bsc[i-1] < sc)
            begin
                bsc[i] = bsc[i-1];
                brw[i] = brw[i-1];
                i--;
            end
            bsc[i] = sc;
            brw[i] = rr;
        end
        if (cnt == 0)
        begin
            push_status(ST_NONE);
            return;
        end
        for (int h = 0; h < cnt; h++)
        begin
            r = '{ST_HIT, row_bk[brw[h]], row_ch[brw[h]], row_vs[brw[h]],
                  bsc[h][SCORE_W-1:0], (h + 1 == cnt)};
            due_results.push_back(r);
        end
    endtask

    // one input beat; called and returns at a rising edge
    task automatic send(input logic [REQ_W-1:0] t, input logic signed [COMP_W-1:0] c,
                        input logic lc, input logic [BOOK_W-1:0] b,
                        input logic [META_W-1:0] ch, input logic [META_W-1:0] vs);
        int gap;
        start <= 1'b1;
        req_type <= t;
        component <= c;
        last_component <= lc;
        book_id <= b;
        chapter_num <= ch;
        verse_num <= vs;
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
        search_predict(t, c, lc, b, ch, vs);
        // sender bursts and gaps
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(1, 6);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 7);
        end
    endtask

    function automatic logic signed [COMP_W-1:0] rand_comp(bit zero);
        if (zero)
            return '0;
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return COMP_W'($urandom_range(0, 200) - 100);
            default: return COMP_W'($urandom);
        endcase
    endfunction

    // whole vector with random content; metadata on every beat, used on the last
    task automatic send_vec(input logic [REQ_W-1:0] t, input int n, input bit zero,
                            input bit mixed);
        logic [REQ_W-1:0] tt;
        for (int i = 0; i < n; i++)
        begin
            tt = mixed ? (($urandom_range(0, 1) == 1) ? REQ_ROW : REQ_QUERY) : t;
            send(tt, rand_comp(zero), i == n - 1, BOOK_W'($urandom_range(0, 999)),
                 META_W'($urandom), META_W'($urandom));
        end
    endtask

    // drain results and let the back end settle before touching registers
    task automatic wait_idle();
        start <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        do
            @(negedge clk);
        while (busy);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= DIMS_W'(val);
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == CFG_DIMS)
            dims_cfg = val & 11'h7ff;
        else if (idx == CFG_HITS)
            hits_cfg = val & 3'h7;
    endtask

    // reset values: refused query on empty index, then a row and query at 384 dims
    task automatic test_reset_defaults();
        send(REQ_QUERY, 16'sh1000, 1'b1, 10'd0, 16'd0, 16'd0);
        send_vec(REQ_ROW, 384, 1'b0, 1'b0);
        send_vec(REQ_QUERY, 384, 1'b0, 1'b0);
    endtask

    // extremes, ties, zero rows and refused queries, mostly on 3-wide vectors
    task automatic test_directed();
        write_reg(CFG_DIMS, 3);
        write_reg(CFG_HITS, 4);
        send(REQ_CLEAR, 16'sh0, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh7fff, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh8000, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh0000, 1'b1, 10'd999, 16'hffff, 16'hffff);
        send(REQ_ROW, 16'sh0001, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh0001, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh0001, 1'b1, 10'd0, 16'd0, 16'd0);
        send_vec(REQ_ROW, 3, 1'b1, 1'b0);
        send(REQ_ROW, 16'sh0001, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh0001, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_ROW, 16'sh0001, 1'b1, 10'd5, 16'd7, 16'd9);
        send(REQ_QUERY, 16'sh7fff, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_QUERY, 16'sh8000, 1'b0, 10'd0, 16'd0, 16'd0);
        send(REQ_QUERY, 16'sh0000, 1'b1, 10'd0, 16'd0, 16'd0);
        send_vec(REQ_QUERY, 3, 1'b1, 1'b0);
        // unused request code is ignored
        send(2'd3, 16'sh1234, 1'b1, 10'd3, 16'd3, 16'd3);
        send_vec(REQ_ROW, 3, 1'b0, 1'b1);
        write_reg(CFG_HITS, 7);
        send_vec(REQ_QUERY, 3, 1'b0, 1'b0);
        write_reg(CFG_HITS, 0);
        send_vec(REQ_QUERY, 3, 1'b0, 1'b0);
        // short row clears the index
        send_vec(REQ_ROW, 2, 1'b0, 1'b0);
        write_reg(CFG_HITS, 2);
        send_vec(REQ_QUERY, 3, 1'b0, 1'b0);
        write_reg(CFG_DIMS, 0);
        send_vec(REQ_ROW, 1, 1'b0, 1'b0);
        write_reg(CFG_DIMS, 2047);
        send_vec(REQ_QUERY, 1, 1'b0, 1'b0);
    endtask

    // widest vectors and a vector past the buffer size
    task automatic test_long_vectors();
        write_reg(CFG_DIMS, MAX_DIMS);
        write_reg(CFG_HITS, 1);
        send_vec(REQ_ROW, MAX_DIMS, 1'b0, 1'b0);
        send_vec(REQ_ROW, MAX_DIMS, 1'b0, 1'b0);
        send_vec(REQ_QUERY, MAX_DIMS, 1'b0, 1'b0);
        send_vec(REQ_ROW, MAX_DIMS + 1, 1'b0, 1'b0);
    endtask

    // fill every row slot, overflow once, then rank many equal scores
    task automatic test_table_full();
        write_reg(CFG_DIMS, 1);
        write_reg(CFG_HITS, 4);
        send(REQ_CLEAR, 16'sh0, 1'b0, 10'd0, 16'd0, 16'd0);
        for (int i = 0; i <= MAX_ROWS; i++)
            send(REQ_ROW, (i % 3 == 0) ? 16'sh4000 : 16'sh7fff, 1'b1,
                 BOOK_W'(i % 1000), META_W'(i), META_W'($urandom));
        send(REQ_QUERY, 16'sh7fff, 1'b1, 10'd0, 16'd0, 16'd0);
        send(REQ_CLEAR, 16'sh0, 1'b0, 10'd0, 16'd0, 16'd0);
    endtask

    // random phases of well-formed rows and queries with some noise
    task automatic test_random();
        int dims;
        int n;
        int pick;
        while (rand_items < 420)
        begin
            dims = ($urandom_range(0, 9) == 0) ? 16 : $urandom_range(1, 8);
            write_reg(CFG_DIMS, dims);
            write_reg(CFG_HITS, $urandom_range(0, 7));
            if ($urandom_range(0, 3) != 0 || n_rows > 40)
                send(REQ_CLEAR, 16'sh0, 1'b0, 10'd0, 16'd0, 16'd0);
            repeat ($urandom_range(4, 12))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 42)
                    send_vec(REQ_ROW, dims, $urandom_range(0, 9) == 0, 1'b0);
                else if (pick < 78)
                    send_vec(REQ_QUERY, dims, $urandom_range(0, 19) == 0, 1'b0);
                else if (pick < 86)
                begin
                    n = (dims == 1 || $urandom_range(0, 1) == 1) ? dims + 1 : dims - 1;
                    send_vec(($urandom_range(0, 1) == 1) ? REQ_ROW : REQ_QUERY,
                             n, 1'b0, 1'b0);
                end
                else if (pick < 90)
                    send(REQ_CLEAR, rand_comp(1'b0), 1'b1, 10'd0, 16'd0, 16'd0);
                else if (pick < 94)
                    send(2'd3, rand_comp(1'b0), 1'b1, 10'd1, 16'd1, 16'd1);
                else
                    send_vec(REQ_ROW, dims, 1'b0, 1'b1);
                if (pick < 90 || pick >= 94)
                    rand_items++;
            end
        end
    endtask

    // check each result beat against the oldest expectation
    always @(negedge clk)
    begin
        search_result_t e;
        if (rst_n && result_valid)
        begin
            if (due_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual status %0d",
                         $time, status);
            end
            else
            begin
                e = due_results.pop_front();
                if (status !== e.status)
                begin
                    errors++;
                    $display("%0t status: expected %0d actual %0d", $time, e.status, status);
                end
                if (hit_book !== e.book)
                begin
                    errors++;
                    $display("%0t hit_book: expected %0d actual %0d", $time, e.book, hit_book);
                end
                if (hit_chapter !== e.chapter)
                begin
                    errors++;
                    $display("%0t hit_chapter: expected %0d actual %0d", $time, e.chapter,
                             hit_chapter);
                end
                if (hit_verse !== e.verse)
                begin
                    errors++;
                    $display("%0t hit_verse: expected %0d actual %0d", $time, e.verse,
                             hit_verse);
                end
                if (hit_score !== e.score)
                begin
                    errors++;
                    $display("%0t hit_score: expected %0d actual %0d", $time, e.score,
                             hit_score);
                end
                if (last_result !== e.last)
                begin
                    errors++;
                    $display("%0t last_result: expected %0d actual %0d", $time, e.last,
                             last_result);
                end
            end
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_directed();
        test_long_vectors();
        test_table_full();
        test_random();
        wait_idle();
        repeat (60) @(posedge clk);
        if (errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> filelist.f
rtl/vtk_pkg.sv
rtl/vtk_front.sv
rtl/vtk_job_fifo.sv
rtl/vtk_back.sv
rtl/int8_vector_topk_search.sv
sim/int8_vector_topk_search_tb.sv
